@@ src/aram_pkg.sv @@
// ----------------------------------------------------------------------------
// aram_pkg
// Constants and acknowledgement string tables for the AT response matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package aram_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int NUM_ACKS         = 4;
  localparam int BYTE_W           = 8;
  localparam int CODE_W           = 2;
  localparam int LEN_W            = 10;
  localparam int POS_W            = 4;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;
  localparam logic [POS_W-1:0]  POS_MAX = 4'd15;

  localparam logic [CODE_W-1:0] ACK_OK    = 2'd0;
  localparam logic [CODE_W-1:0] ACK_ERROR = 2'd1;
  localparam logic [CODE_W-1:0] ACK_BUSY  = 2'd2;
  localparam logic [CODE_W-1:0] ACK_READY = 2'd3;

  typedef logic [NUM_ACKS-1:0] alive_t;

  // length of each acknowledgement line, newline included
  function automatic logic [POS_W-1:0] ack_len(input logic [CODE_W-1:0] code);
    logic [POS_W-1:0] len;
    case (code)
      ACK_OK:    len = 4'd4;
      ACK_ERROR: len = 4'd7;
      ACK_BUSY:  len = 4'd6;
      ACK_READY: len = 4'd7;
      default:   len = 4'd0;
    endcase
    return len;
  endfunction

  // expected character of an acknowledgement at a line position
  function automatic logic [BYTE_W-1:0] ack_char(input logic [CODE_W-1:0] code,
                                                 input logic [2:0] pos);
    logic [BYTE_W-1:0] ch;
    ch = 8'h00;
    case (code)
      ACK_OK: begin
        case (pos)
          3'd0:    ch = "O";
          3'd1:    ch = "K";
          3'd2:    ch = 8'h0D;
          3'd3:    ch = 8'h0A;
          default: ch = 8'h00;
        endcase
      end
      ACK_ERROR: begin
        case (pos)
          3'd0:    ch = "E";
          3'd1:    ch = "R";
          3'd2:    ch = "R";
          3'd3:    ch = "O";
          3'd4:    ch = "R";
          3'd5:    ch = 8'h0D;
          3'd6:    ch = 8'h0A;
          default: ch = 8'h00;
        endcase
      end
      ACK_BUSY: begin
        case (pos)
          3'd0:    ch = "b";
          3'd1:    ch = "u";
          3'd2:    ch = "s";
          3'd3:    ch = "y";
          3'd4:    ch = 8'h0D;
          3'd5:    ch = 8'h0A;
          default: ch = 8'h00;
        endcase
      end
      ACK_READY: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "a";
          3'd3:    ch = "d";
          3'd4:    ch = "y";
          3'd5:    ch = 8'h0D;
          3'd6:    ch = 8'h0A;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ src/at_response_ack_matcher.sv @@
// ----------------------------------------------------------------------------
// at_response_ack_matcher
// Counts received bytes of a modem response and reports an acknowledgement
// code with the byte count when a line equals OK, ERROR, busy or ready.
// ----------------------------------------------------------------------------
// channel  ports                                         direction
// in       in_valid, in_ready, in_rx_byte                beat in, one byte
// out      out_valid, out_ready, out_ack_code,
//          out_response_length                           beat out, one result
//
// One byte per cycle sustained, except while a stalled result holds stage one.
// Stage one holds the byte, stage two updates the line state and loads the
// result register. Reset clears count, line state and both valid flags.
// A stalled result holds stage one only for bytes that end a matched line.
// Once the count reaches BUFFER_BYTES-2, bytes are dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_ack_matcher #(
  parameter int BUFFER_BYTES = aram_pkg::BUFFER_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [aram_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [aram_pkg::CODE_W-1:0]  out_ack_code,
  output logic [aram_pkg::LEN_W-1:0]   out_response_length
);

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam int EXT_W = (CNT_W > aram_pkg::LEN_W) ? CNT_W : aram_pkg::LEN_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES - 2);

  logic                         s1_valid_r;
  logic [aram_pkg::BYTE_W-1:0]  s1_byte_r;
  logic [CNT_W-1:0]             byte_count_r, byte_count_nxt;
  logic [aram_pkg::POS_W-1:0]   line_pos_r, line_pos_nxt;
  aram_pkg::alive_t             alive_r, alive_nxt, alive_upd;
  logic                         out_valid_r;
  logic [aram_pkg::CODE_W-1:0]  out_code_r, code_nxt;
  logic [aram_pkg::LEN_W-1:0]   out_len_r;
  logic [CNT_W-1:0]             count_inc;
  logic [EXT_W-1:0]             count_ext;
  logic                         full;
  logic                         is_nl;
  logic                         hit;
  logic                         s1_fire;
  logic                         in_fire;

  assign full      = (byte_count_r >= CNT_LIMIT);
  assign count_inc = byte_count_r + CNT_W'(1);
  assign count_ext = EXT_W'(count_inc);
  assign is_nl     = (s1_byte_r == aram_pkg::NEWLINE);

  always_comb begin
    alive_upd = alive_r;
    hit       = 1'b0;
    code_nxt  = aram_pkg::ACK_OK;
    for (int k = 0; k < aram_pkg::NUM_ACKS; k++) begin
      if (!((line_pos_r < aram_pkg::ack_len(aram_pkg::CODE_W'(k))) &&
            (aram_pkg::ack_char(aram_pkg::CODE_W'(k), line_pos_r[2:0]) == s1_byte_r))) begin
        alive_upd[k] = 1'b0;
      end
    end
    for (int k = aram_pkg::NUM_ACKS - 1; k >= 0; k--) begin
      if (alive_upd[k] &&
          (line_pos_r + aram_pkg::POS_W'(1) == aram_pkg::ack_len(aram_pkg::CODE_W'(k)))) begin
        hit      = is_nl;
        code_nxt = aram_pkg::CODE_W'(k);
      end
    end
  end

  assign s1_fire  = s1_valid_r && (full || !hit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    byte_count_nxt = byte_count_r;
    line_pos_nxt   = line_pos_r;
    alive_nxt      = alive_r;
    if (s1_fire && !full) begin
      if (!is_nl) begin
        byte_count_nxt = count_inc;
        line_pos_nxt   = (line_pos_r < aram_pkg::POS_MAX) ?
                         line_pos_r + aram_pkg::POS_W'(1) : aram_pkg::POS_MAX;
        alive_nxt      = alive_upd;
      end else begin
        byte_count_nxt = hit ? '0 : count_inc;
        line_pos_nxt   = '0;
        alive_nxt      = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_count_r <= '0;
      line_pos_r   <= '0;
      alive_r      <= '1;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && !full && hit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      byte_count_r <= byte_count_nxt;
      line_pos_r   <= line_pos_nxt;
      alive_r      <= alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_fire && !full && hit) begin
      out_code_r <= code_nxt;
      out_len_r  <= count_ext[aram_pkg::LEN_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ack_code        = out_code_r;
  assign out_response_length = out_len_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_LIMIT)
    else $error("byte count beyond buffer limit");

  a_clear_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !full && hit) |=> (byte_count_r == '0) && out_valid_r)
    else $error("acknowledgement did not clear count or load result");

  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (line_pos_r == '0) |-> (alive_r == '1))
    else $error("pattern flags not restored at line start");

  a_long_line: assert property (@(posedge clk) disable iff (!rst_n)
    (line_pos_r >= aram_pkg::POS_W'(8)) |-> (alive_r == '0))
    else $error("pattern alive on a line longer than any acknowledgement");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_fire && !full && hit))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ dv/at_response_ack_matcher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_ack_matcher_tb
// Streams modem response bytes into the matcher and checks each reported
// acknowledgement code and byte count against a line-matching predictor.
// Covers clean and broken acknowledgement lines, long and zero-laden lines
// and the buffer-full lock-out, with random valid and ready gaps on both
// channels.
// ----------------------------------------------------------------------------

module at_response_ack_matcher_tb;

  import aram_pkg::*;

  localparam int BUF_BYTES  = BUFFER_BYTES_DEF;
  localparam int FULL_COUNT = BUF_BYTES - 2;
  localparam int RAND_BYTES = 830;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 20;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } ack_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CODE_W-1:0]   out_ack_code;
  logic [LEN_W-1:0]    out_response_length;

  logic [BYTE_W-1:0]   rx_pending[$];
  ack_result_t         ack_expected[$];

  int                  resp_count = 0;
  int                  line_pos = 0;
  alive_t              match_alive = '1;

  int                  in_gap = 0;
  int                  in_calm = 0;
  int                  out_gap = 0;
  int                  out_calm = 0;
  int                  idle_cycles = 0;
  int                  error_count = 0;

  at_response_ack_matcher #(
    .BUFFER_BYTES(BUF_BYTES)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ack_code        (out_ack_code),
    .out_response_length (out_response_length)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] ack_pattern(input logic [CODE_W-1:0] code);
    logic [63:0] pat;
    case (code)
      ACK_OK:    pat = {"OK", 8'h0D, 8'h0A, 32'h0};
      ACK_ERROR: pat = {"ERROR", 8'h0D, 8'h0A, 8'h00};
      ACK_BUSY:  pat = {"busy", 8'h0D, 8'h0A, 16'h0};
      default:   pat = {"ready", 8'h0D, 8'h0A, 8'h00};
    endcase
    return pat;
  endfunction

  function automatic int ack_length(input logic [CODE_W-1:0] code);
    int n;
    case (code)
      ACK_OK:    n = 4;
      ACK_ERROR: n = 7;
      ACK_BUSY:  n = 6;
      default:   n = 7;
    endcase
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] ack_byte(input logic [CODE_W-1:0] code,
                                                 input int pos);
    logic [63:0] pat;
    pat = ack_pattern(code);
    return pat[63-8*pos -: 8];
  endfunction

  function automatic logic [BYTE_W-1:0] junk_byte();
    logic [BYTE_W-1:0] b;
    do
      b = BYTE_W'($urandom_range(0, 255));
    while (b == NEWLINE);
    return b;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 6) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 400) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 970) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    int          p;
    alive_t      alive;
    bit          hit;
    ack_result_t res;
    if (resp_count >= FULL_COUNT) return;
    resp_count++;
    p = line_pos;
    alive = match_alive;
    for (int k = 0; k < NUM_ACKS; k++) begin
      if (!(p < ack_length(k[CODE_W-1:0]) && ack_byte(k[CODE_W-1:0], p) == b))
        alive[k] = 1'b0;
    end
    if (b != NEWLINE) begin
      line_pos = (p < POS_MAX) ? p + 1 : POS_MAX;
      match_alive = alive;
      return;
    end
    line_pos = 0;
    match_alive = '1;
    hit = 1'b0;
    for (int k = 0; k < NUM_ACKS; k++) begin
      if (!hit && alive[k] && p + 1 == ack_length(k[CODE_W-1:0])) begin
        hit = 1'b1;
        res.code = k[CODE_W-1:0];
        res.length = resp_count[LEN_W-1:0];
        ack_expected.push_back(res);
        resp_count = 0;
      end
    end
  endtask

  task automatic push_ack_span(input logic [CODE_W-1:0] code, input int from, input int upto);
    for (int i = from; i < upto; i++)
      rx_pending.push_back(ack_byte(code, i));
  endtask

  task automatic push_junk(input int n);
    for (int i = 0; i < n; i++)
      rx_pending.push_back(junk_byte());
  endtask

  task automatic push_random_line();
    int                r;
    int                n;
    int                cut;
    logic [CODE_W-1:0] code;
    r = $urandom_range(0, 99);
    code = CODE_W'($urandom_range(0, 3));
    n = ack_length(code);
    if (r < 45) begin
      push_ack_span(code, 0, n);
    end else if (r < 55) begin
      // truncate before the carriage return
      cut = $urandom_range(0, n - 2);
      push_ack_span(code, 0, cut);
      rx_pending.push_back(NEWLINE);
    end else if (r < 65) begin
      cut = $urandom_range(0, n - 2);
      push_ack_span(code, 0, cut);
      rx_pending.push_back(r < 60 ? junk_byte() : (ack_byte(code, cut) ^ 8'h20));
      push_ack_span(code, cut + 1, n);
    end else if (r < 72) begin
      cut = $urandom_range(0, n - 2);
      push_ack_span(code, 0, cut);
      rx_pending.push_back(junk_byte());
      push_ack_span(code, cut, n);
    end else if (r < 82) begin
      push_junk($urandom_range(0, 20));
      rx_pending.push_back(NEWLINE);
    end else if (r < 88) begin
      push_junk($urandom_range(12, 30));
      push_ack_span(code, 0, n);
    end else if (r < 95) begin
      push_junk($urandom_range(1, 5));
    end else begin
      cut = $urandom_range(0, n - 1);
      push_ack_span(code, 0, cut);
      rx_pending.push_back(8'h00);
      push_ack_span(code, cut, n);
    end
  endtask

  // driver: predict on acceptance, then refill the input slot
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      if (in_valid && in_ready)
        predict_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_pending.pop_front();
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    ack_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ack_expected.size() == 0) begin
          $error("unexpected result: ack_code %0d response_length %0d",
                 out_ack_code, out_response_length);
          error_count++;
        end else begin
          want = ack_expected.pop_front();
          if (out_ack_code !== want.code) begin
            $error("ack_code: expected %0d, actual %0d", want.code, out_ack_code);
            error_count++;
          end
          if (out_response_length !== want.length) begin
            $error("response_length: expected %0d, actual %0d",
                   want.length, out_response_length);
            error_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int start_size;

    // each acknowledgement, bare newline, zero byte inside a line
    push_ack_span(ACK_OK, 0, ack_length(ACK_OK));
    push_ack_span(ACK_ERROR, 0, ack_length(ACK_ERROR));
    push_ack_span(ACK_BUSY, 0, ack_length(ACK_BUSY));
    push_ack_span(ACK_READY, 0, ack_length(ACK_READY));
    rx_pending.push_back(NEWLINE);
    rx_pending.push_back(8'h00);
    push_ack_span(ACK_OK, 0, ack_length(ACK_OK));
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(NEWLINE);

    start_size = rx_pending.size();
    while (rx_pending.size() < start_size + RAND_BYTES)
      push_random_line();

    // close the open line, then clear the count with a clean acknowledgement
    rx_pending.push_back(NEWLINE);
    rx_pending.push_back(NEWLINE);
    push_ack_span(ACK_OK, 0, ack_length(ACK_OK));

    // fill the buffer, then everything after is dropped
    push_junk(FULL_COUNT + 8);
    rx_pending.push_back(NEWLINE);
    push_ack_span(ACK_READY, 0, ack_length(ACK_READY));
    push_ack_span(ACK_OK, 0, ack_length(ACK_OK));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_pending.size() > 0 || in_valid)
      @(posedge clk);
    while (ack_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/aram_pkg.sv
src/at_response_ack_matcher.sv
dv/at_response_ack_matcher_tb.sv
